// ===== sv/mieu_pkg.sv =====
// Package for the MIPS integer execute unit: payload structs, opcodes and
// the command and status structs between controller and datapath. No dependencies.
`default_nettype none
package mieu_pkg;

   typedef struct packed {
      logic [31:0] instr_word;
      logic [31:0] instr_pc;
   } req_type;

   typedef struct packed {
      logic        reg_write_en;
      logic [4:0]  reg_write_idx;
      logic [31:0] reg_write_val;
      logic        branch_pending;
      logic [31:0] branch_target;
      logic [1:0]  exc_code;
   } rsp_type;

   localparam logic [1:0] EXC_NONE = 2'd0;
   localparam logic [1:0] EXC_OVF  = 2'd1;
   localparam logic [1:0] EXC_BRK  = 2'd2;
   localparam logic [1:0] EXC_RSV  = 2'd3;

   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_REGIMM  = 6'h01;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_BLEZ    = 6'h06;
   localparam logic [5:0] OP_BGTZ    = 6'h07;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTI    = 6'h0A;
   localparam logic [5:0] OP_ANDI    = 6'h0C;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_LUI     = 6'h0F;

   localparam logic [5:0] FN_SLL   = 6'h00;
   localparam logic [5:0] FN_SLLV  = 6'h04;
   localparam logic [5:0] FN_JR    = 6'h08;
   localparam logic [5:0] FN_JALR  = 6'h09;
   localparam logic [5:0] FN_BREAK = 6'h0D;
   localparam logic [5:0] FN_MFHI  = 6'h10;
   localparam logic [5:0] FN_MTHI  = 6'h11;
   localparam logic [5:0] FN_MFLO  = 6'h12;
   localparam logic [5:0] FN_MTLO  = 6'h13;
   localparam logic [5:0] FN_MULT  = 6'h18;
   localparam logic [5:0] FN_MULTU = 6'h19;
   localparam logic [5:0] FN_DIV   = 6'h1A;
   localparam logic [5:0] FN_DIVU  = 6'h1B;
   localparam logic [5:0] FN_ADD   = 6'h20;
   localparam logic [5:0] FN_ADDU  = 6'h21;
   localparam logic [5:0] FN_AND   = 6'h24;
   localparam logic [5:0] FN_OR    = 6'h25;
   localparam logic [5:0] FN_NOR   = 6'h27;
   localparam logic [5:0] FN_SLT   = 6'h2A;

   localparam logic [4:0] RI_BLTZ   = 5'h00;
   localparam logic [4:0] RI_BGEZ   = 5'h01;
   localparam logic [4:0] RI_BLTZAL = 5'h10;
   localparam logic [4:0] RI_BGEZAL = 5'h11;

   localparam logic [4:0] LINK_REG  = 5'd31;
   localparam int         LUI_SHIFT = 16;

   typedef struct packed {
      logic latch;     // capture the request and read the register file
      logic execute;   // run the ALU and branch path on the latched operands
      logic md_start;  // start a multiply or divide
      logic md_step;   // advance the multiply or divide by one bit
      logic md_finish; // write HI and LO and build the response
   } cmd_type;

   typedef struct packed {
      logic is_md;     // latched instruction is a multiply or divide
      logic md_last;   // all iterations of the multiply or divide are done
   } sts_type;

endpackage
`default_nettype wire

// ===== sv/mips_integer_execute_unit.sv =====
// MIPS integer execute unit, top level.
// Joins the controller and the datapath. Depends on mieu_pkg, mieu_ctrl and mieu_dpath.
//
// Usage:
// The request channel (req_valid, req_ready, req_data) carries one instruction
// word and its PC per transfer. The response channel (rsp_valid, rsp_ready,
// rsp_data) returns one result per instruction: register write, branch target
// and exception code.
// A non-multiply/divide instruction is latched and the register file read in the
// transfer cycle, executed in the next, and its response is valid in the cycle
// after; the next request is taken in the cycle the response is transferred.
// Multiply and divide run a radix-2 iteration of 32 steps.
// At reset the register file, HI and LO read as zero and both channels idle.
// While the receiver stalls the response is held and no new request is taken.
`default_nettype none
module mips_integer_execute_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mieu_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mieu_pkg::rsp_type      rsp_data
);
   mieu_pkg::cmd_type cmd;
   mieu_pkg::sts_type sts;

   mieu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mieu_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );
endmodule
`default_nettype wire

// ===== sv/mieu_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mieu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end
endmodule
`default_nettype wire

// ===== sv/mieu_ctrl.sv =====
// Controller state machine of the execute unit: sequences latch, execute,
// multiply/divide iterations and the response. Depends on mieu_pkg.
`default_nettype none
module mieu_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire mieu_pkg::sts_type sts,
   output mieu_pkg::cmd_type      cmd
);
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DEC  = 4'b0010,
      ST_MD   = 4'b0100,
      ST_RSP  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_fire;

   assign rsp_fire  = (state_ff == ST_RSP) && rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || rsp_fire;
   assign rsp_valid = (state_ff == ST_RSP);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DEC;
            end
         end
         ST_DEC: begin
            if (sts.is_md) begin
               cmd.md_start = 1'b1;
               state_in     = ST_MD;
            end else begin
               cmd.execute = 1'b1;
               state_in    = ST_RSP;
            end
         end
         ST_MD: begin
            if (sts.md_last) begin
               cmd.md_finish = 1'b1;
               state_in      = ST_RSP;
            end else begin
               cmd.md_step = 1'b1;
            end
         end
         ST_RSP: begin
            if (rsp_ready) begin
               if (req_valid) begin
                  cmd.latch = 1'b1;
                  state_in  = ST_DEC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// ===== sv/mieu_dpath.sv =====
// Datapath of the execute unit: register file, HI/LO, ALU, branch logic and
// a radix-2 multiply/divide unit. Depends on mieu_pkg and mieu_ram.
`default_nettype none
module mieu_dpath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mieu_pkg::req_type req_data,
   input  wire mieu_pkg::cmd_type cmd,
   output mieu_pkg::sts_type      sts,
   output mieu_pkg::rsp_type      rsp_data
);
   mieu_pkg::req_type req_ff;
   mieu_pkg::rsp_type rsp_ff, rsp_in;
   logic [31:0] rd_a, rd_b, vs, vt;
   logic [31:0] hi_ff, hi_in, lo_ff, lo_in;
   logic [31:0] valid_ff;
   logic        wr_en;
   logic [4:0]  wr_idx;
   logic [31:0] wr_val;
   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd, sa;
   logic [15:0] imm;
   logic [31:0] simm, btarget, link, pc4, jtarget, sum, sumi;
   logic        is_md;

   // Multiply/divide iteration state.
   logic [31:0] acc_ff, acc_in;   // product high half or partial remainder
   logic [31:0] q_ff, q_in;       // multiplier/product low or quotient
   logic [31:0] m_ff, m_in;       // multiplicand or divisor magnitude
   logic [5:0]  cnt_ff, cnt_in;
   logic        md_div_ff, md_div_in, neg_q_ff, neg_q_in, neg_r_ff, neg_r_in;
   logic        md_skip_ff, md_skip_in;
   logic [32:0] madd;
   logic [32:0] dsub;
   logic [31:0] dacc;
   logic [63:0] prod, prod_neg;
   logic [31:0] qfin, rfin;

   assign op  = req_ff.instr_word[31:26];
   assign rs  = req_ff.instr_word[25:21];
   assign rt  = req_ff.instr_word[20:16];
   assign rd  = req_ff.instr_word[15:11];
   assign sa  = req_ff.instr_word[10:6];
   assign fn  = req_ff.instr_word[5:0];
   assign imm = req_ff.instr_word[15:0];

   mieu_ram #(.WIDTH(32), .DEPTH(32)) u_gpr (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_idx),
      .wr_data   (wr_val),
      .rd_en     (cmd.latch),
      .rd_addr_a (req_data.instr_word[25:21]),
      .rd_addr_b (req_data.instr_word[20:16]),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // The previous instruction writes in its execute state, before the next read,
   // so registered read data is always current. Unwritten entries read zero.
   assign vs = valid_ff[rs] ? rd_a : 32'd0;
   assign vt = valid_ff[rt] ? rd_b : 32'd0;

   assign wr_en  = cmd.execute && rsp_in.reg_write_en;
   assign wr_idx = rsp_in.reg_write_idx;
   assign wr_val = rsp_in.reg_write_val;

   assign is_md = (op == mieu_pkg::OP_SPECIAL) &&
      ((fn == mieu_pkg::FN_MULT) || (fn == mieu_pkg::FN_MULTU) ||
       (fn == mieu_pkg::FN_DIV) || (fn == mieu_pkg::FN_DIVU));
   assign sts.is_md   = is_md;
   assign sts.md_last = (cnt_ff == 6'd0);

   assign simm    = {{16{imm[15]}}, imm};
   assign link    = req_ff.instr_pc + 32'd8;
   assign pc4     = req_ff.instr_pc + 32'd4;
   assign btarget = pc4 + {simm[29:0], 2'b00};
   assign jtarget = {pc4[31:28], req_ff.instr_word[25:0], 2'b00};
   assign sum     = vs + vt;
   assign sumi    = vs + simm;

   always_comb begin
      logic        wen, bp, take;
      logic [4:0]  widx;
      logic [31:0] wval, tgt;
      logic [1:0]  exc;
      wen  = 1'b0;
      bp   = 1'b0;
      take = 1'b0;
      widx = rd;
      wval = 32'd0;
      tgt  = btarget;
      exc  = mieu_pkg::EXC_NONE;
      hi_in = hi_ff;
      lo_in = lo_ff;
      unique case (op)
         mieu_pkg::OP_SPECIAL: begin
            unique case (fn)
               mieu_pkg::FN_SLL:   begin wen = 1'b1; wval = vt << sa; end
               mieu_pkg::FN_SLLV:  begin wen = 1'b1; wval = vt << vs[4:0]; end
               mieu_pkg::FN_JR:    begin bp = 1'b1; tgt = vs; end
               mieu_pkg::FN_JALR:  begin bp = 1'b1; tgt = vs; wen = 1'b1; wval = link; end
               mieu_pkg::FN_BREAK: exc = mieu_pkg::EXC_BRK;
               mieu_pkg::FN_MFHI:  begin wen = 1'b1; wval = hi_ff; end
               mieu_pkg::FN_MTHI:  hi_in = vs;
               mieu_pkg::FN_MFLO:  begin wen = 1'b1; wval = lo_ff; end
               mieu_pkg::FN_MTLO:  lo_in = vs;
               mieu_pkg::FN_MULT, mieu_pkg::FN_MULTU,
               mieu_pkg::FN_DIV, mieu_pkg::FN_DIVU: ;
               mieu_pkg::FN_ADD: begin
                  if ((vs[31] ^ sum[31]) & (vt[31] ^ sum[31])) begin
                     exc = mieu_pkg::EXC_OVF;
                  end else begin
                     wen = 1'b1; wval = sum;
                  end
               end
               mieu_pkg::FN_ADDU: begin wen = 1'b1; wval = sum; end
               mieu_pkg::FN_AND:  begin wen = 1'b1; wval = vs & vt; end
               mieu_pkg::FN_OR:   begin wen = 1'b1; wval = vs | vt; end
               mieu_pkg::FN_NOR:  begin wen = 1'b1; wval = ~(vs | vt); end
               mieu_pkg::FN_SLT: begin
                  wen = 1'b1; wval = {31'd0, $signed(vs) < $signed(vt)};
               end
               default: exc = mieu_pkg::EXC_RSV;
            endcase
         end
         mieu_pkg::OP_REGIMM: begin
            unique case (rt)
               mieu_pkg::RI_BLTZ: take = vs[31];
               mieu_pkg::RI_BGEZ: take = !vs[31];
               mieu_pkg::RI_BLTZAL: begin
                  take = vs[31]; wen = 1'b1; widx = mieu_pkg::LINK_REG; wval = link;
               end
               mieu_pkg::RI_BGEZAL: begin
                  take = !vs[31]; wen = 1'b1; widx = mieu_pkg::LINK_REG; wval = link;
               end
               default: exc = mieu_pkg::EXC_RSV;
            endcase
         end
         mieu_pkg::OP_J: begin bp = 1'b1; tgt = jtarget; end
         mieu_pkg::OP_JAL: begin
            bp = 1'b1; tgt = jtarget; wen = 1'b1; widx = mieu_pkg::LINK_REG; wval = link;
         end
         mieu_pkg::OP_BEQ:  take = (vs == vt);
         mieu_pkg::OP_BNE:  take = (vs != vt);
         mieu_pkg::OP_BLEZ: take = vs[31] || (vs == 32'd0);
         mieu_pkg::OP_BGTZ: take = !vs[31] && (vs != 32'd0);
         mieu_pkg::OP_ADDI: begin
            widx = rt;
            if ((vs[31] ^ sumi[31]) & (simm[31] ^ sumi[31])) begin
               exc = mieu_pkg::EXC_OVF;
            end else begin
               wen = 1'b1; wval = sumi;
            end
         end
         mieu_pkg::OP_ADDIU: begin wen = 1'b1; widx = rt; wval = sumi; end
         mieu_pkg::OP_SLTI: begin
            wen = 1'b1; widx = rt; wval = {31'd0, $signed(vs) < $signed(simm)};
         end
         mieu_pkg::OP_ANDI: begin wen = 1'b1; widx = rt; wval = vs & {16'd0, imm}; end
         mieu_pkg::OP_ORI:  begin wen = 1'b1; widx = rt; wval = vs | {16'd0, imm}; end
         mieu_pkg::OP_LUI: begin
            wen = 1'b1; widx = rt; wval = {imm, 16'd0} << (mieu_pkg::LUI_SHIFT - 16);
         end
         default: exc = mieu_pkg::EXC_RSV;
      endcase
      if (take) begin
         bp = 1'b1;
      end
      if (widx == 5'd0) begin
         wen = 1'b0;
      end
      rsp_in.reg_write_en   = wen;
      rsp_in.reg_write_idx  = wen ? widx : 5'd0;
      rsp_in.reg_write_val  = wen ? wval : 32'd0;
      rsp_in.branch_pending = bp;
      rsp_in.branch_target  = bp ? tgt : 32'd0;
      rsp_in.exc_code       = exc;
   end

   // Multiply/divide: 32 shift-add or restoring-subtract steps on magnitudes.
   assign madd = {1'b0, acc_ff} + (q_ff[0] ? {1'b0, m_ff} : 33'd0);
   assign dacc = {acc_ff[30:0], q_ff[31]};
   assign dsub = {acc_ff[31], dacc} - {1'b0, m_ff};
   assign prod     = {acc_ff, q_ff};
   assign prod_neg = 64'd0 - prod;
   assign qfin     = neg_q_ff ? 32'd0 - q_ff : q_ff;
   assign rfin     = neg_r_ff ? 32'd0 - acc_ff : acc_ff;

   always_comb begin
      logic sgn;
      acc_in     = acc_ff;
      q_in       = q_ff;
      m_in       = m_ff;
      cnt_in     = cnt_ff;
      md_div_in  = md_div_ff;
      neg_q_in   = neg_q_ff;
      neg_r_in   = neg_r_ff;
      md_skip_in = md_skip_ff;
      sgn        = (fn == mieu_pkg::FN_MULT) || (fn == mieu_pkg::FN_DIV);
      if (cmd.md_start) begin
         acc_in     = 32'd0;
         q_in       = (sgn && vs[31]) ? 32'd0 - vs : vs;
         m_in       = (sgn && vt[31]) ? 32'd0 - vt : vt;
         cnt_in     = 6'd32;
         md_div_in  = (fn == mieu_pkg::FN_DIV) || (fn == mieu_pkg::FN_DIVU);
         neg_q_in   = sgn && (vs[31] ^ vt[31]);
         neg_r_in   = sgn && vs[31];
         md_skip_in = (vt == 32'd0) &&
                      ((fn == mieu_pkg::FN_DIV) || (fn == mieu_pkg::FN_DIVU));
      end else if (cmd.md_step) begin
         cnt_in = cnt_ff - 6'd1;
         if (md_div_ff) begin
            if (!dsub[32]) begin
               acc_in = dsub[31:0];
               q_in   = {q_ff[30:0], 1'b1};
            end else begin
               acc_in = dacc;
               q_in   = {q_ff[30:0], 1'b0};
            end
         end else begin
            acc_in = madd[32:1];
            q_in   = {madd[0], q_ff[31:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hi_ff    <= 32'd0;
         lo_ff    <= 32'd0;
         cnt_ff   <= 6'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (cmd.execute) begin
            hi_ff <= hi_in;
            lo_ff <= lo_in;
         end else if (cmd.md_finish && !md_skip_ff) begin
            if (md_div_ff) begin
               hi_ff <= rfin;
               lo_ff <= qfin;
            end else if (neg_q_ff) begin
               hi_ff <= prod_neg[63:32];
               lo_ff <= prod_neg[31:0];
            end else begin
               hi_ff <= prod[63:32];
               lo_ff <= prod[31:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      q_ff       <= q_in;
      m_ff       <= m_in;
      md_div_ff  <= md_div_in;
      neg_q_ff   <= neg_q_in;
      neg_r_ff   <= neg_r_in;
      md_skip_ff <= md_skip_in;
      if (cmd.latch) begin
         req_ff <= req_data;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end else if (cmd.md_finish) begin
         rsp_ff <= '0;
      end
   end

   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

// ===== dv/mips_integer_execute_unit_tb.sv =====
// Testbench for the MIPS integer execute unit: drives instruction transfers,
// predicts each response with an internal execution model and compares them.
// Depends on mieu_pkg and mips_integer_execute_unit.
`timescale 1ns / 100ps
`default_nettype none
module mips_integer_execute_unit_tb;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   mieu_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   mieu_pkg::rsp_type rsp_data;

   mips_integer_execute_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   mieu_pkg::req_type pending_instrs[$];
   mieu_pkg::rsp_type expected_results[$];
   logic [31:0]       model_gpr[32];
   logic [31:0]       model_hi;
   logic [31:0]       model_lo;
   int                error_count = 0;
   bit                stimulus_done = 0;
   bit                calm = 0;
   bit                req_taken = 0;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [31:0] sext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic mieu_pkg::rsp_type execute_instr(input mieu_pkg::req_type r);
      mieu_pkg::rsp_type o;
      logic [5:0]  op;
      logic [5:0]  fn;
      logic [4:0]  rs;
      logic [4:0]  rt;
      logic [4:0]  rd;
      logic [4:0]  sa;
      logic [15:0] imm;
      logic [31:0] vs;
      logic [31:0] vt;
      logic [31:0] bt;
      logic [31:0] link;
      logic [31:0] jt;
      logic [31:0] s;
      logic [63:0] p;
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] q;
      logic [31:0] rm;
      op = r.instr_word[31:26];
      rs = r.instr_word[25:21];
      rt = r.instr_word[20:16];
      rd = r.instr_word[15:11];
      sa = r.instr_word[10:6];
      fn = r.instr_word[5:0];
      imm = r.instr_word[15:0];
      vs = model_gpr[rs];
      vt = model_gpr[rt];
      bt = r.instr_pc + 32'd4 + (sext16(imm) << 2);
      link = r.instr_pc + 32'd8;
      jt = ((r.instr_pc + 32'd4) & 32'hF000_0000) | {4'b0, r.instr_word[25:0], 2'b0};
      o = '0;
      case (op)
         mieu_pkg::OP_SPECIAL: begin
            case (fn)
               mieu_pkg::FN_SLL: begin
                  o.reg_write_en = 1'b1; o.reg_write_idx = rd; o.reg_write_val = vt << sa;
               end
               mieu_pkg::FN_SLLV: begin
                  o.reg_write_en = 1'b1; o.reg_write_idx = rd;
                  o.reg_write_val = vt << vs[4:0];
               end
               mieu_pkg::FN_JR: begin o.branch_pending = 1'b1; o.branch_target = vs; end
               mieu_pkg::FN_JALR: begin
                  o.branch_pending = 1'b1; o.branch_target = vs;
                  o.reg_write_en = 1'b1; o.reg_write_idx = rd; o.reg_write_val = link;
               end
               mieu_pkg::FN_BREAK: o.exc_code = mieu_pkg::EXC_BRK;
               mieu_pkg::FN_MFHI: begin
                  o.reg_write_en = 1'b1; o.reg_write_idx = rd; o.reg_write_val = model_hi;
               end
               mieu_pkg::FN_MTHI: model_hi = vs;
               mieu_pkg::FN_MFLO: begin
                  o.reg_write_en = 1'b1; o.reg_write_idx = rd; o.reg_write_val = model_lo;
               end
               mieu_pkg::FN_MTLO: model_lo = vs;
               mieu_pkg::FN_MULT: begin
                  p = $signed({{32{vs[31]}}, vs}) * $signed({{32{vt[31]}}, vt});
                  model_lo = p[31:0]; model_hi = p[63:32];
               end
               mieu_pkg::FN_MULTU: begin
                  p = {32'b0, vs} * {32'b0, vt};
                  model_lo = p[31:0]; model_hi = p[63:32];
               end
               mieu_pkg::FN_DIV: if (vt != 0) begin
                  ma = vs[31] ? -vs : vs;
                  mb = vt[31] ? -vt : vt;
                  q = ma / mb;
                  rm = ma % mb;
                  if (vs[31] ^ vt[31]) q = -q;
                  if (vs[31]) rm = -rm;
                  model_lo = q; model_hi = rm;
               end
               mieu_pkg::FN_DIVU: if (vt != 0) begin
                  model_lo = vs / vt; model_hi = vs % vt;
               end
               mieu_pkg::FN_ADD: begin
                  s = vs + vt;
                  if (vs[31] == vt[31] && s[31] != vs[31]) o.exc_code = mieu_pkg::EXC_OVF;
                  else begin
                     o.reg_write_en = 1'b1; o.reg_write_idx = rd; o.reg_write_val = s;
                  end
               end
               mieu_pkg::FN_ADDU: begin
                  o.reg_write_en = 1'b1; o.reg_write_idx = rd; o.reg_write_val = vs + vt;
               end
               mieu_pkg::FN_AND: begin
                  o.reg_write_en = 1'b1; o.reg_write_idx = rd; o.reg_write_val = vs & vt;
               end
               mieu_pkg::FN_OR: begin
                  o.reg_write_en = 1'b1; o.reg_write_idx = rd; o.reg_write_val = vs | vt;
               end
               mieu_pkg::FN_NOR: begin
                  o.reg_write_en = 1'b1; o.reg_write_idx = rd; o.reg_write_val = ~(vs | vt);
               end
               mieu_pkg::FN_SLT: begin
                  o.reg_write_en = 1'b1; o.reg_write_idx = rd;
                  o.reg_write_val = ($signed(vs) < $signed(vt)) ? 32'd1 : 32'd0;
               end
               default: o.exc_code = mieu_pkg::EXC_RSV;
            endcase
         end
         mieu_pkg::OP_REGIMM: begin
            case (rt)
               mieu_pkg::RI_BLTZ: if (vs[31]) begin
                  o.branch_pending = 1'b1; o.branch_target = bt;
               end
               mieu_pkg::RI_BGEZ: if (!vs[31]) begin
                  o.branch_pending = 1'b1; o.branch_target = bt;
               end
               mieu_pkg::RI_BLTZAL, mieu_pkg::RI_BGEZAL: begin
                  if (vs[31] == (rt == mieu_pkg::RI_BLTZAL)) begin
                     o.branch_pending = 1'b1; o.branch_target = bt;
                  end
                  o.reg_write_en = 1'b1; o.reg_write_idx = mieu_pkg::LINK_REG;
                  o.reg_write_val = link;
               end
               default: o.exc_code = mieu_pkg::EXC_RSV;
            endcase
         end
         mieu_pkg::OP_J: begin o.branch_pending = 1'b1; o.branch_target = jt; end
         mieu_pkg::OP_JAL: begin
            o.branch_pending = 1'b1; o.branch_target = jt;
            o.reg_write_en = 1'b1; o.reg_write_idx = mieu_pkg::LINK_REG;
            o.reg_write_val = link;
         end
         mieu_pkg::OP_BEQ: if (vs == vt) begin
            o.branch_pending = 1'b1; o.branch_target = bt;
         end
         mieu_pkg::OP_BNE: if (vs != vt) begin
            o.branch_pending = 1'b1; o.branch_target = bt;
         end
         mieu_pkg::OP_BLEZ: if (vs[31] || vs == 0) begin
            o.branch_pending = 1'b1; o.branch_target = bt;
         end
         mieu_pkg::OP_BGTZ: if (!vs[31] && vs != 0) begin
            o.branch_pending = 1'b1; o.branch_target = bt;
         end
         mieu_pkg::OP_ADDI: begin
            s = vs + sext16(imm);
            if (vs[31] == imm[15] && s[31] != vs[31]) o.exc_code = mieu_pkg::EXC_OVF;
            else begin
               o.reg_write_en = 1'b1; o.reg_write_idx = rt; o.reg_write_val = s;
            end
         end
         mieu_pkg::OP_ADDIU: begin
            o.reg_write_en = 1'b1; o.reg_write_idx = rt; o.reg_write_val = vs + sext16(imm);
         end
         mieu_pkg::OP_SLTI: begin
            o.reg_write_en = 1'b1; o.reg_write_idx = rt;
            o.reg_write_val = ($signed(vs) < $signed(sext16(imm))) ? 32'd1 : 32'd0;
         end
         mieu_pkg::OP_ANDI: begin
            o.reg_write_en = 1'b1; o.reg_write_idx = rt; o.reg_write_val = vs & {16'b0, imm};
         end
         mieu_pkg::OP_ORI: begin
            o.reg_write_en = 1'b1; o.reg_write_idx = rt; o.reg_write_val = vs | {16'b0, imm};
         end
         mieu_pkg::OP_LUI: begin
            o.reg_write_en = 1'b1; o.reg_write_idx = rt;
            o.reg_write_val = {16'b0, imm} << mieu_pkg::LUI_SHIFT;
         end
         default: o.exc_code = mieu_pkg::EXC_RSV;
      endcase
      if (o.reg_write_en && o.reg_write_idx == 5'd0) o.reg_write_en = 1'b0;
      if (o.reg_write_en) model_gpr[o.reg_write_idx] = o.reg_write_val;
      else begin o.reg_write_idx = '0; o.reg_write_val = '0; end
      if (!o.branch_pending) o.branch_target = '0;
      return o;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic logic [31:0] rtype(input logic [4:0] rs, input logic [4:0] rt,
                                         input logic [4:0] rd, input logic [4:0] sa,
                                         input logic [5:0] fn);
      return {mieu_pkg::OP_SPECIAL, rs, rt, rd, sa, fn};
   endfunction

   function automatic logic [31:0] itype(input logic [5:0] op, input logic [4:0] rs,
                                         input logic [4:0] rt, input logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [31:0] random_word();
      logic [5:0] fns[18];
      logic [5:0] ops[13];
      logic [4:0] ris[4];
      logic [4:0] rs;
      logic [4:0] rt;
      logic [4:0] rd;
      logic [15:0] imm;
      int k;
      fns = '{mieu_pkg::FN_SLL, mieu_pkg::FN_SLLV, mieu_pkg::FN_JR, mieu_pkg::FN_JALR,
              mieu_pkg::FN_BREAK, mieu_pkg::FN_MFHI, mieu_pkg::FN_MTHI, mieu_pkg::FN_MFLO,
              mieu_pkg::FN_MTLO, mieu_pkg::FN_MULT, mieu_pkg::FN_MULTU, mieu_pkg::FN_DIV,
              mieu_pkg::FN_DIVU, mieu_pkg::FN_ADD, mieu_pkg::FN_ADDU, mieu_pkg::FN_AND,
              mieu_pkg::FN_OR, mieu_pkg::FN_SLT};
      ops = '{mieu_pkg::OP_REGIMM, mieu_pkg::OP_J, mieu_pkg::OP_JAL, mieu_pkg::OP_BEQ,
              mieu_pkg::OP_BNE, mieu_pkg::OP_BLEZ, mieu_pkg::OP_BGTZ, mieu_pkg::OP_ADDI,
              mieu_pkg::OP_ADDIU, mieu_pkg::OP_SLTI, mieu_pkg::OP_ANDI, mieu_pkg::OP_ORI,
              mieu_pkg::OP_LUI};
      ris = '{mieu_pkg::RI_BLTZ, mieu_pkg::RI_BGEZ, mieu_pkg::RI_BLTZAL,
              mieu_pkg::RI_BGEZAL};
      rs = 5'($urandom_range(0, 7));
      rt = 5'($urandom_range(0, 7));
      rd = 5'($urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) begin
         rs = 5'($urandom); rt = 5'($urandom); rd = 5'($urandom);
      end
      case ($urandom_range(0, 3))
         0: imm = 16'($urandom);
         1: imm = 16'($urandom_range(0, 15));
         2: imm = 16'hFFFF - 16'($urandom_range(0, 15));
         default: imm = (($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF) ^
                        16'($urandom_range(0, 3));
      endcase
      k = $urandom_range(0, 99);
      if (k < 5) return $urandom;
      if (k < 10) return rtype(rs, rt, rd, 5'($urandom), mieu_pkg::FN_NOR);
      if (k < 20) return itype(mieu_pkg::OP_LUI, 5'd0, rt, imm);
      if (k < 55) return rtype(rs, rt, rd, 5'($urandom), fns[$urandom_range(0, 17)]);
      if (k < 62) return itype(mieu_pkg::OP_REGIMM, rs, ris[$urandom_range(0, 3)], imm);
      return {ops[$urandom_range(0, 12)], rs, rt, imm};
   endfunction

   initial begin
      mieu_pkg::req_type r;
      reset = 1'b1;
      for (int i = 0; i < 32; i++) model_gpr[i] = '0;
      model_hi = '0;
      model_lo = '0;
      r.instr_pc = 32'h0000_0100;
      r.instr_word = itype(mieu_pkg::OP_LUI, 5'd0, 5'd1, 16'h8000);
      pending_instrs.push_back(r);
      r.instr_word = itype(mieu_pkg::OP_ADDI, 5'd1, 5'd2, 16'hFFFF);
      pending_instrs.push_back(r);
      r.instr_word = itype(mieu_pkg::OP_ADDIU, 5'd0, 5'd3, 16'hFFFF);
      pending_instrs.push_back(r);
      r.instr_word = rtype(5'd1, 5'd3, 5'd0, 5'd0, mieu_pkg::FN_DIV);
      pending_instrs.push_back(r);
      r.instr_word = rtype(5'd0, 5'd0, 5'd4, 5'd0, mieu_pkg::FN_MFLO);
      pending_instrs.push_back(r);
      r.instr_word = rtype(5'd0, 5'd0, 5'd5, 5'd0, mieu_pkg::FN_MFHI);
      pending_instrs.push_back(r);
      r.instr_word = rtype(5'd3, 5'd0, 5'd0, 5'd0, mieu_pkg::FN_DIVU);
      pending_instrs.push_back(r);
      r.instr_word = rtype(5'd0, 5'd0, 5'd6, 5'd0, mieu_pkg::FN_MFLO);
      pending_instrs.push_back(r);
      r.instr_word = rtype(5'd3, 5'd3, 5'd7, 5'd0, mieu_pkg::FN_MULT);
      pending_instrs.push_back(r);
      r.instr_word = rtype(5'd3, 5'd3, 5'd7, 5'd0, mieu_pkg::FN_MULTU);
      pending_instrs.push_back(r);
      r.instr_word = rtype(5'd0, 5'd0, 5'd7, 5'd0, mieu_pkg::FN_MFHI);
      pending_instrs.push_back(r);
      r.instr_word = rtype(5'd1, 5'd1, 5'd8, 5'd0, mieu_pkg::FN_ADD);
      pending_instrs.push_back(r);
      r.instr_word = rtype(5'd3, 5'd3, 5'd9, 5'd31, mieu_pkg::FN_SLL);
      pending_instrs.push_back(r);
      r.instr_word = rtype(5'd3, 5'd3, 5'd9, 5'd0, mieu_pkg::FN_SLLV);
      pending_instrs.push_back(r);
      r.instr_word = itype(mieu_pkg::OP_ANDI, 5'd3, 5'd10, 16'hFFFF);
      pending_instrs.push_back(r);
      r.instr_word = itype(mieu_pkg::OP_ADDI, 5'd3, 5'd0, 16'h0001);
      pending_instrs.push_back(r);
      r.instr_word = rtype(5'd1, 5'd0, 5'd11, 5'd0, mieu_pkg::FN_SLT);
      pending_instrs.push_back(r);
      r.instr_word = itype(mieu_pkg::OP_REGIMM, 5'd31, mieu_pkg::RI_BLTZAL, 16'h8000);
      pending_instrs.push_back(r);
      r.instr_word = itype(mieu_pkg::OP_REGIMM, 5'd1, mieu_pkg::RI_BGEZAL, 16'h7FFF);
      pending_instrs.push_back(r);
      r.instr_pc = 32'hFFFF_FFFC;
      r.instr_word = {mieu_pkg::OP_JAL, 26'h3FF_FFFF};
      pending_instrs.push_back(r);
      r.instr_word = rtype(5'd1, 5'd0, 5'd12, 5'd0, mieu_pkg::FN_JALR);
      pending_instrs.push_back(r);
      r.instr_word = rtype(5'd0, 5'd0, 5'd0, 5'd0, mieu_pkg::FN_BREAK);
      pending_instrs.push_back(r);
      r.instr_word = 32'hFFFF_FFFF;
      pending_instrs.push_back(r);
      r.instr_word = itype(mieu_pkg::OP_BLEZ, 5'd0, 5'd0, 16'h0000);
      pending_instrs.push_back(r);
      for (int i = 0; i < 1350; i++) begin
         r.instr_word = random_word();
         r.instr_pc = ($urandom_range(0, 3) == 0) ? $urandom :
                      {22'd0, 8'($urandom_range(0, 255)), 2'b00};
         pending_instrs.push_back(r);
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   initial begin
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
   end

   always @(negedge clock) begin
      calm <= ($realtime > 3000 && $realtime < 6000);
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (pending_instrs.size() != 0 && (calm || $urandom_range(0, 99) >= 19)) begin
               req_valid <= 1'b1;
               req_data <= pending_instrs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= calm || $urandom_range(0, 99) >= 19;
      end
   end

   always @(posedge clock) begin
      mieu_pkg::rsp_type want;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         expected_results.push_back(execute_instr(req_data));
         if (pending_instrs.size() == 0) stimulus_done <= 1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("response with nothing expected", '0, '0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_data.reg_write_en !== want.reg_write_en)
               report_mismatch("reg_write_en", 32'(rsp_data.reg_write_en),
                               32'(want.reg_write_en));
            if (rsp_data.reg_write_idx !== want.reg_write_idx)
               report_mismatch("reg_write_idx", 32'(rsp_data.reg_write_idx),
                               32'(want.reg_write_idx));
            if (rsp_data.reg_write_val !== want.reg_write_val)
               report_mismatch("reg_write_val", rsp_data.reg_write_val, want.reg_write_val);
            if (rsp_data.branch_pending !== want.branch_pending)
               report_mismatch("branch_pending", 32'(rsp_data.branch_pending),
                               32'(want.branch_pending));
            if (rsp_data.branch_target !== want.branch_target)
               report_mismatch("branch_target", rsp_data.branch_target, want.branch_target);
            if (rsp_data.exc_code !== want.exc_code)
               report_mismatch("exc_code", 32'(rsp_data.exc_code), 32'(want.exc_code));
         end
      end
   end

   initial begin
      wait (stimulus_done);
      while (expected_results.size() != 0 || req_valid) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("mips_integer_execute_unit test passed");
      end else begin
         $display("mips_integer_execute_unit test failed");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("mips_integer_execute_unit test failed");
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
sv/mieu_pkg.sv
sv/mieu_ram.sv
sv/mieu_ctrl.sv
sv/mieu_dpath.sv
sv/mips_integer_execute_unit.sv
dv/mips_integer_execute_unit_tb.sv
